// File: rtl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg: shared types and constants for the character LCD nibble sequencer
// Holds the request codes, sequencer phases, timing register set, sequencer
// state, result record and the command tables for the 4-bit LCD bus.
// ----------------------------------------------------------------------------
package clcd_pkg;

    localparam int ROWS    = 4;
    localparam int COLUMNS = 20;

    localparam int TICK_W  = 20;
    localparam int PULSE_W = 8;
    localparam int SETTLE_W = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_TICKS      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE_TICKS     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_WAIT_TICKS  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_FINAL_TICKS = 2'd3;

    localparam logic [7:0] CMD_CLEAR = 8'h01;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_CMD   = 3'd1,
        OP_DATA  = 3'd2,
        OP_GOTO  = 3'd3,
        OP_CLEAR = 3'd4,
        OP_INIT  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_POWERUP = 3'd1,
        PH_HI_EN   = 3'd2,
        PH_HI_FALL = 3'd3,
        PH_LO_EN   = 3'd4,
        PH_SETTLE  = 3'd5,
        PH_EXTRA   = 3'd6,
        PH_FINAL   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [PULSE_W-1:0]  pulse_ticks;
        logic [SETTLE_W-1:0] settle_ticks;
        logic [TICK_W-1:0]   long_wait_ticks;
        logic [TICK_W-1:0]   init_final_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [7:0]          held_byte;
        logic                held_rs;
        logic [TICK_W-1:0]   tick_count;
        logic [TICK_W-1:0]   extra_wait;
        logic [2:0]          init_step;
    } seq_state_t;

    typedef struct packed {
        logic       rs;
        logic       enable;
        logic [3:0] nibble;
        logic       busy_res;
        logic       rejected;
    } result_t;

    // DDRAM base address per display line (row given from zero)
    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        case (r)
            2'd0: b = 8'h80;
            2'd1: b = 8'hC0;
            2'd2: b = 8'h94;
            default: b = 8'hD4;
        endcase
        return b;
    endfunction

    // Power-up command list: function set, display on, entry mode, DDRAM address 0
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: c = 8'h28;
            2'd1: c = 8'h0C;
            2'd2: c = 8'h06;
            default: c = 8'h80;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/clcd_step.sv
// ----------------------------------------------------------------------------
// clcd_step: next-state and pin logic of the LCD sequencer
// Applies one tick or request to the current sequencer state and gives the
// new state with the bus levels and status that follow from it.
// ----------------------------------------------------------------------------
module clcd_step
    import clcd_pkg::*;
(
    input  seq_state_t  cur,
    input  cfg_t        cfg,
    input  op_t         op,
    input  logic [7:0]  byte_value,
    input  logic [2:0]  row,
    input  logic [5:0]  column,
    output seq_state_t  nxt,
    output result_t     res
);

    logic              busy;
    logic              bad_pos;
    logic              rej;
    logic              do_adv;
    logic [TICK_W:0]   tc1;
    logic [TICK_W-1:0] len;
    logic [7:0]        goto_byte;

    assign busy = (cur.phase != PH_IDLE);
    assign tc1  = {1'b0, cur.tick_count} + {{TICK_W{1'b0}}, 1'b1};

    assign bad_pos = (op == OP_GOTO) &&
        ((row == 3'd0) || (row > 3'(ROWS)) || (column == 6'd0) || (column > 6'(COLUMNS)));

    assign goto_byte = row_base(2'(row - 3'd1)) + {2'b00, column} - 8'd1;

    always_comb begin
        case (cur.phase)
            PH_POWERUP: len = cfg.long_wait_ticks;
            PH_HI_EN, PH_LO_EN: len = {{(TICK_W-PULSE_W){1'b0}}, cfg.pulse_ticks};
            PH_SETTLE: len = {{(TICK_W-SETTLE_W){1'b0}}, cfg.settle_ticks};
            PH_EXTRA: len = cur.extra_wait;
            PH_FINAL: len = cfg.init_final_ticks;
            default: len = TICK_W'(1);
        endcase
    end

    always_comb begin
        nxt    = cur;
        rej    = 1'b0;
        do_adv = 1'b0;
        case (op)
            OP_TICK: begin
                if (busy) begin
                    if (tc1 >= {1'b0, len}) begin
                        do_adv = 1'b1;
                    end else begin
                        nxt.tick_count = tc1[TICK_W-1:0];
                    end
                end
            end
            OP_CMD, OP_DATA, OP_GOTO, OP_CLEAR, OP_INIT: begin
                if (busy || bad_pos) begin
                    rej = 1'b1;
                end else begin
                    nxt.init_step  = 3'd0;
                    nxt.tick_count = '0;
                    nxt.held_rs    = 1'b0;
                    nxt.extra_wait = '0;
                    nxt.phase      = PH_HI_EN;
                    case (op)
                        OP_CMD: nxt.held_byte = byte_value;
                        OP_DATA: begin
                            nxt.held_byte = byte_value;
                            nxt.held_rs   = 1'b1;
                        end
                        OP_GOTO: begin
                            nxt.held_byte  = goto_byte;
                            nxt.extra_wait = cfg.long_wait_ticks;
                        end
                        OP_CLEAR: begin
                            nxt.held_byte  = CMD_CLEAR;
                            nxt.extra_wait = cfg.long_wait_ticks;
                        end
                        default: begin
                            nxt.held_byte = 8'h00;
                            nxt.phase     = PH_POWERUP;
                        end
                    endcase
                end
            end
            default: ;
        endcase

        if (do_adv) begin
            nxt.tick_count = '0;
            case (cur.phase)
                PH_POWERUP: begin
                    nxt.init_step  = 3'd1;
                    nxt.held_byte  = init_cmd(2'd0);
                    nxt.held_rs    = 1'b0;
                    nxt.extra_wait = '0;
                    nxt.phase      = PH_HI_EN;
                end
                PH_HI_EN: nxt.phase = PH_HI_FALL;
                PH_HI_FALL: nxt.phase = PH_LO_EN;
                PH_LO_EN: nxt.phase = PH_SETTLE;
                PH_SETTLE, PH_EXTRA: begin
                    if (cur.phase == PH_SETTLE && cur.extra_wait != '0) begin
                        nxt.phase = PH_EXTRA;
                    end else if (cur.init_step >= 3'd1 && cur.init_step <= 3'd3) begin
                        // send the next power-up command
                        nxt.held_byte  = init_cmd(cur.init_step[1:0]);
                        nxt.held_rs    = 1'b0;
                        nxt.extra_wait = '0;
                        nxt.phase      = PH_HI_EN;
                        nxt.init_step  = cur.init_step + 3'd1;
                    end else if (cur.init_step == 3'd4) begin
                        nxt.init_step = 3'd0;
                        nxt.phase     = PH_FINAL;
                    end else begin
                        nxt.init_step = 3'd0;
                        nxt.phase     = PH_IDLE;
                    end
                end
                default: nxt.phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        res.rs       = nxt.held_rs;
        res.enable   = (nxt.phase == PH_HI_EN) || (nxt.phase == PH_LO_EN);
        res.nibble   = ((nxt.phase == PH_HI_EN) || (nxt.phase == PH_HI_FALL)) ?
                       nxt.held_byte[7:4] : nxt.held_byte[3:0];
        res.busy_res = (nxt.phase != PH_IDLE);
        res.rejected = rej;
    end

endmodule

// File: rtl/char_lcd_nibble_write_sequencer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit: 4-bit character LCD write sequencer
//
// Input stream: each item is a microsecond tick or a request (command byte,
// data byte, cursor goto, clear, init); s_tuser carries the request code.
// Every accepted item yields exactly one result item on the m_ channel with
// the RS, E and D7..D4 levels after the item plus busy and rejected flags.
// Requests arriving while a sequence runs, and gotos off the screen, come
// back rejected and leave the sequence untouched.
// State updates at the edge that accepts the item; the result enters the
// result register, or the skid register while one waits. Throughput is one
// item per cycle while s_tready is high; each is one 21-bit add and compare.
// A two-entry output stage (result register plus skid register) lets an item
// be taken while a result waits; s_tready drops only when both are full.
// Reset (aresetn low, synchronous) returns the sequencer to idle with the
// bus at zero, empties the output stage and loads the default timing
// registers: pulse 2, settle 300, long wait 10000, init final 20000 ticks.
// Timing registers are written through cfg_wr_en/cfg_addr/cfg_wr_data.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_unit
    import clcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // byte_value[7:0], row[10:8], column[16:11]
    input  logic [2:0]            s_tuser,   // op[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // enable[0], nibble[4:1], busy_res[5], rejected[6]
    output logic                  m_tuser,   // rs[0]
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_next;
    result_t    out_reg;
    result_t    skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    logic       accept;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    clcd_step u_step (
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .op         (op_t'(s_tuser)),
        .byte_value (s_tdata[7:0]),
        .row        (s_tdata[10:8]),
        .column     (s_tdata[16:11]),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ticks      <= PULSE_W'(2);
            cfg_reg.settle_ticks     <= SETTLE_W'(300);
            cfg_reg.long_wait_ticks  <= TICK_W'(10000);
            cfg_reg.init_final_ticks <= TICK_W'(20000);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PULSE_TICKS:      cfg_reg.pulse_ticks      <= cfg_wr_data[PULSE_W-1:0];
                CFG_SETTLE_TICKS:     cfg_reg.settle_ticks     <= cfg_wr_data[SETTLE_W-1:0];
                CFG_LONG_WAIT_TICKS:  cfg_reg.long_wait_ticks  <= cfg_wr_data[TICK_W-1:0];
                CFG_INIT_FINAL_TICKS: cfg_reg.init_final_ticks <= cfg_wr_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_IDLE;
            state_reg.held_byte  <= 8'h00;
            state_reg.held_rs    <= 1'b0;
            state_reg.tick_count <= '0;
            state_reg.extra_wait <= '0;
            state_reg.init_step  <= 3'd0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Output stage: result register backed by one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res_next;
            end
        end else if (accept) begin
            skid_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.rs;
    assign m_tdata  = {1'b0, out_reg.rejected, out_reg.busy_res, out_reg.nibble, out_reg.enable};

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_enable_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.enable) |-> out_reg.busy_res)
        else $error("enable strobe reported while sequencer idle");

    a_init_step_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.init_step != 3'd0) |-> (state_reg.phase != PH_IDLE))
        else $error("init step pending while sequencer idle");

    a_reject_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_next.rejected) |=> (state_reg == $past(state_reg)))
        else $error("rejected request changed sequencer state");
`endif

endmodule
